FILE: rtl/binomial_mod_prime_core_defines.svh
// Assertion macros shared by the binomial coefficient core.
`ifndef BINOMIAL_MOD_PRIME_CORE_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the core clock and masked during reset.
`define BMP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the core clock and masked during reset.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/bmp_pkg.sv
// Types, constants and command encodings for the binomial coefficient core.
package bmp_pkg;

   // Field widths of the request and the result.
   localparam int ARG_W = 12;
   localparam int VAL_W = 30;

   // Modulus and the Fermat exponent used for inversion.
   localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd1000000007;
   localparam logic [VAL_W-1:0] FERMAT_EXP = PRIME_MOD - 30'd2;
   localparam int               EXP_BITS   = VAL_W;
   localparam int               BIT_W      = $clog2(EXP_BITS);

   // Barrett reduction factor floor(2^60 / P), which fits in 31 bits.
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME_MOD));

   // Factorial table size and its address width.
   localparam int TABLE_SIZE = 4096;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);

   // Modular multiplier has three register stages; one exponent step spans four slots.
   localparam int               SLOT_W      = 2;
   localparam logic [SLOT_W-1:0] SLOT_SQR    = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_MUL    = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_RESULT = 2'd2;
   localparam logic [SLOT_W-1:0] SLOT_LAST   = 2'd3;

   // Request and result payloads.
   typedef struct packed {
      logic [ARG_W-1:0] n_total;
      logic [ARG_W-1:0] r_chosen;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] binom_value;
      logic             r_too_large;
   } rsp_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_FILL_START,
      ST_FILL_MUL,
      ST_FILL_WAIT,
      ST_IDLE,
      ST_CHECK,
      ST_RD_D,
      ST_RD_N,
      ST_RD_LAST,
      ST_DEN_WAIT,
      ST_EXP,
      ST_DRAIN,
      ST_FIN,
      ST_FIN_WAIT,
      ST_DONE
   } ctrl_state_type;

   // Multiplier operations; each selects operands and a destination register.
   typedef enum logic [2:0] {
      MOP_FILL,
      MOP_DEN,
      MOP_SQR,
      MOP_ACC,
      MOP_FIN
   } mop_type;

   // Table read address selection.
   typedef enum logic [1:0] {
      ADDR_N,
      ADDR_R,
      ADDR_D
   } addr_sel_type;

   // Destination of table read data.
   typedef enum logic [1:0] {
      LD_NONE,
      LD_ACC,
      LD_BASE,
      LD_FN
   } ld_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         fill_start;
      logic         idx_inc;
      addr_sel_type rd_sel;
      ld_sel_type   ld_sel;
      logic         mul_go;
      mop_type      mul_op;
      logic         acc_one;
      logic         rsp_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic r_gt_n;
      logic n_out_range;
      logic fill_last;
   } dp_status_type;

endpackage

FILE: rtl/bmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bmp_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bmp_modmul.sv
// Pipelined modular multiplier modulo P using Barrett reduction.
module bmp_modmul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  bmp_pkg::mop_type             in_tag,
   input  logic [bmp_pkg::VAL_W-1:0]    in_a,
   input  logic [bmp_pkg::VAL_W-1:0]    in_b,
   output logic                         res_valid,
   output bmp_pkg::mop_type             res_tag,
   output logic [bmp_pkg::VAL_W-1:0]    res_value
);
   import bmp_pkg::*;

   localparam logic [31:0] PRIME_32  = 32'(PRIME_MOD);
   localparam logic [31:0] PRIME2_32 = 32'(PRIME_MOD) << 1;

   logic [59:0] prod_ff, prod_in;
   logic [61:0] q2_full;
   logic [30:0] q3_ff, q3_in;
   logic [31:0] lo2_ff, lo3_ff;
   logic [31:0] qp_ff, qp_in;
   logic [2:0]  vld_ff, vld_in;
   mop_type     tag1_ff, tag2_ff, tag3_ff;
   logic [31:0] rem;
   logic [31:0] rem_sub1;
   logic [31:0] rem_sub2;

   // Stage one: full product. Stage two: quotient estimate. Stage three: q*P.
   assign prod_in = 60'(in_a) * 60'(in_b);
   assign q2_full = 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
   assign q3_in   = q2_full[61:31];
   assign qp_in   = 32'(q3_ff) * PRIME_32;
   assign vld_in  = {vld_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      tag1_ff <= in_tag;
      q3_ff   <= q3_in;
      lo2_ff  <= prod_ff[31:0];
      tag2_ff <= tag1_ff;
      qp_ff   <= qp_in;
      lo3_ff  <= lo2_ff;
      tag3_ff <= tag2_ff;
   end

   // The Barrett remainder is below 3P; at most two subtractions of P remain.
   assign rem      = lo3_ff - qp_ff;
   assign rem_sub1 = rem - PRIME_32;
   assign rem_sub2 = rem - PRIME2_32;

   always_comb begin
      priority if (rem >= PRIME2_32) begin
         res_value = rem_sub2[VAL_W-1:0];
      end else if (rem >= PRIME_32) begin
         res_value = rem_sub1[VAL_W-1:0];
      end else begin
         res_value = rem[VAL_W-1:0];
      end
   end

   assign res_valid = vld_ff[2];
   assign res_tag   = tag3_ff;

endmodule

FILE: rtl/bmp_datapath.sv
// Datapath: operand registers, factorial table, modular multiplier and result register.
module bmp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  bmp_pkg::req_type       req_data,
   input  bmp_pkg::dp_cmd_type    cmd,
   output bmp_pkg::dp_status_type status,
   output bmp_pkg::rsp_type       rsp_data
);
   import bmp_pkg::*;

   logic [ARG_W-1:0]  n_ff, n_in;
   logic [ARG_W-1:0]  r_ff, r_in;
   logic [VAL_W-1:0]  acc_ff, acc_in;
   logic [VAL_W-1:0]  base_ff, base_in;
   logic [VAL_W-1:0]  fn_ff, fn_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [VAL_W-1:0]  mul_a;
   logic [VAL_W-1:0]  mul_b;
   logic              res_valid;
   mop_type           res_tag;
   logic [VAL_W-1:0]  res_value;
   logic              res_to_acc;
   logic              res_to_base;
   logic              res_to_table;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [VAL_W-1:0]  ram_wr_data;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [VAL_W-1:0]  ram_rd_data;
   logic [ARG_W-1:0]  n_minus_r;
   logic              no_value;

   // Request checks used by the controller.
   assign status.r_gt_n      = r_ff > n_ff;
   assign status.n_out_range = 32'(n_ff) >= 32'(TABLE_SIZE);
   assign status.fill_last   = idx_ff == ADDR_W'(TABLE_SIZE - 1);

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (cmd.mul_op)
         MOP_FILL: begin
            mul_a = acc_ff;
            mul_b = VAL_W'(idx_ff);
         end
         MOP_DEN, MOP_ACC: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
         MOP_SQR: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         MOP_FIN: begin
            mul_a = acc_ff;
            mul_b = fn_ff;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = base_ff;
         end
      endcase
   end

   bmp_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cmd.mul_go),
      .in_tag    (cmd.mul_op),
      .in_a      (mul_a),
      .in_b      (mul_b),
      .res_valid (res_valid),
      .res_tag   (res_tag),
      .res_value (res_value)
   );

   // Destination decode of the returning product.
   assign res_to_acc   = res_valid && (res_tag == MOP_FILL || res_tag == MOP_ACC ||
                                       res_tag == MOP_FIN);
   assign res_to_base  = res_valid && (res_tag == MOP_DEN || res_tag == MOP_SQR);
   assign res_to_table = res_valid && (res_tag == MOP_FILL);

   // Factorial table: entry zero is written directly, the rest by the fill products.
   assign ram_wr_en   = cmd.fill_start || res_to_table;
   assign ram_wr_addr = cmd.fill_start ? '0 : idx_ff;
   assign ram_wr_data = cmd.fill_start ? VAL_W'(1) : res_value;
   assign n_minus_r   = n_ff - r_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         ADDR_N:  ram_rd_addr = ADDR_W'(n_ff);
         ADDR_R:  ram_rd_addr = ADDR_W'(r_ff);
         ADDR_D:  ram_rd_addr = ADDR_W'(n_minus_r);
         default: ram_rd_addr = ADDR_W'(r_ff);
      endcase
   end

   bmp_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_SIZE)
   ) u_fact_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Operand register updates.
   always_comb begin
      n_in = cmd.capture ? req_data.n_total  : n_ff;
      r_in = cmd.capture ? req_data.r_chosen : r_ff;

      priority if (cmd.fill_start || cmd.acc_one) begin
         acc_in = VAL_W'(1);
      end else if (res_to_acc) begin
         acc_in = res_value;
      end else if (cmd.ld_sel == LD_ACC) begin
         acc_in = ram_rd_data;
      end else begin
         acc_in = acc_ff;
      end

      priority if (res_to_base) begin
         base_in = res_value;
      end else if (cmd.ld_sel == LD_BASE) begin
         base_in = ram_rd_data;
      end else begin
         base_in = base_ff;
      end

      fn_in = (cmd.ld_sel == LD_FN) ? ram_rd_data : fn_ff;

      priority if (cmd.fill_start) begin
         idx_in = ADDR_W'(1);
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   // Result register; out-of-contract arguments give zero.
   assign no_value = status.r_gt_n || status.n_out_range;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_data_in.binom_value = no_value ? '0 : acc_ff;
         rsp_data_in.r_too_large = status.r_gt_n;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      r_ff        <= r_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      fn_ff       <= fn_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

FILE: rtl/bmp_ctrl.sv
// Controller: sequences the table fill, the table reads, exponentiation and hand-off.
module bmp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bmp_pkg::dp_status_type status,
   output bmp_pkg::dp_cmd_type    cmd
);
   import bmp_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_free;
   logic              exp_last;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign exp_last = bit_ff == BIT_W'(EXP_BITS - 1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL_START: state_in = ST_FILL_MUL;
         ST_FILL_MUL:   state_in = ST_FILL_WAIT;
         ST_FILL_WAIT: begin
            if (slot_ff == SLOT_RESULT) begin
               state_in = status.fill_last ? ST_IDLE : ST_FILL_MUL;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (status.r_gt_n || status.n_out_range) ? ST_DONE : ST_RD_D;
         end
         ST_RD_D:    state_in = ST_RD_N;
         ST_RD_N:    state_in = ST_RD_LAST;
         ST_RD_LAST: state_in = ST_DEN_WAIT;
         ST_DEN_WAIT: begin
            if (slot_ff == SLOT_RESULT) begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (slot_ff == SLOT_LAST && exp_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_FIN;
         ST_FIN:   state_in = ST_FIN_WAIT;
         ST_FIN_WAIT: begin
            if (slot_ff == SLOT_RESULT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_FILL_START;
      endcase
   end

   // Datapath commands and handshake outputs.
   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = ADDR_R;
      cmd.ld_sel     = LD_NONE;
      cmd.mul_op     = MOP_ACC;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_FILL_START: cmd.fill_start = 1'b1;
         ST_FILL_MUL: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MOP_FILL;
         end
         ST_FILL_WAIT: begin
            cmd.idx_inc = slot_ff == SLOT_RESULT && !status.fill_last;
         end
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_CHECK: cmd.rd_sel = ADDR_R;
         ST_RD_D: begin
            cmd.rd_sel = ADDR_D;
            cmd.ld_sel = LD_BASE;
         end
         ST_RD_N: begin
            cmd.rd_sel = ADDR_N;
            cmd.ld_sel = LD_ACC;
         end
         ST_RD_LAST: begin
            // Denominator r! * (n-r)! goes to the base register.
            cmd.ld_sel = LD_FN;
            cmd.mul_go = 1'b1;
            cmd.mul_op = MOP_DEN;
         end
         ST_DEN_WAIT: cmd.acc_one = 1'b1;
         ST_EXP: begin
            // Square first, then multiply by the old base when the exponent bit is set.
            if (slot_ff == SLOT_SQR) begin
               cmd.mul_go = 1'b1;
               cmd.mul_op = MOP_SQR;
            end else if (slot_ff == SLOT_MUL) begin
               cmd.mul_go = FERMAT_EXP[bit_ff];
               cmd.mul_op = MOP_ACC;
            end
         end
         ST_DRAIN: cmd.mul_op = MOP_FIN;
         ST_FIN: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MOP_FIN;
         end
         ST_FIN_WAIT: cmd.mul_op = MOP_FIN;
         ST_DONE:     cmd.rsp_load = rsp_free;
         default:     cmd.mul_op = MOP_ACC;
      endcase
   end

   // Slot counter restarts on every state change; exponent bit counts within ST_EXP.
   always_comb begin
      slot_in = (state_in != state_ff) ? '0 : slot_ff + 1'b1;
      if (state_ff != ST_EXP) begin
         bit_in = '0;
      end else if (slot_ff == SLOT_LAST) begin
         bit_in = bit_ff + 1'b1;
      end else begin
         bit_in = bit_ff;
      end
   end

   // Result valid holds until the consumer takes it.
   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_START;
         slot_ff      <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/binomial_mod_prime_core.sv
// Top level of the binomial coefficient modulo 1000000007 core.
//
//   Channel   Direction   Handshake             Payload
//   req_      in          req_valid/req_stall   req_data  (n_total, r_chosen)
//   rsp_      out         rsp_valid/rsp_stall   rsp_data  (binom_value, r_too_large)
//
// A request runs through the table reads and the denominator product, thirty exponent steps
// on the shared three-stage multiplier, then the final product and the result load; a new
// request is taken only after the previous one has loaded its result. When r exceeds n the
// core goes from the check straight to the result load. The table fill after reset runs with
// req_stall high. A finished result waits in the output register while the next request runs;
// that request completes once it is free.
`include "binomial_mod_prime_core_defines.svh"

module binomial_mod_prime_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bmp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output bmp_pkg::rsp_type rsp_data
);
   import bmp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bmp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   bmp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

   // Checks on the result and on request acceptance.
   `BMP_ASSERT_IMPLY(a_value_reduced, rsp_valid, rsp_data.binom_value < PRIME_MOD, "result not reduced modulo P")
   `BMP_ASSERT_IMPLY(a_flag_gives_zero, rsp_valid && rsp_data.r_too_large, rsp_data.binom_value == '0, "flagged result is not zero")
   `BMP_ASSERT_NEXT(a_busy_after_request, req_valid && !req_stall, req_stall, "request accepted while busy")

endmodule

FILE: tb/binomial_mod_prime_core_checker.sv
// Checker for the binomial coefficient core: predicts and compares each rsp_ result.
`timescale 1ns / 1ps

module binomial_mod_prime_core_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  bmp_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  bmp_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               outstanding
);
   import bmp_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Factorials modulo the prime, built once at time zero.
   logic [VAL_W-1:0] fact_mod [TABLE_SIZE];
   // Results predicted for accepted requests, oldest first.
   rsp_type          pending_binoms [$];

   function automatic logic [VAL_W-1:0] mod_product(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      logic [63:0] wide;
      wide = 64'(a) * 64'(b);
      return VAL_W'(wide % 64'(PRIME_MOD));
   endfunction

   // Inverse by Fermat: raise x to P-2, scanning the exponent from its low bit.
   function automatic logic [VAL_W-1:0] mod_inverse(logic [VAL_W-1:0] x);
      logic [VAL_W-1:0] power;
      logic [VAL_W-1:0] acc;
      power = x;
      acc   = VAL_W'(1);
      for (int b = 0; b < VAL_W; b++) begin
         if (FERMAT_EXP[b]) begin
            acc = mod_product(acc, power);
         end
         power = mod_product(power, power);
      end
      return acc;
   endfunction

   // C(n,r) mod P, or zero with the flag set when r exceeds n.
   function automatic rsp_type predict_binom(req_type q);
      rsp_type res;
      int      n_idx;
      int      r_idx;
      n_idx           = int'(q.n_total);
      r_idx           = int'(q.r_chosen);
      res.binom_value = '0;
      res.r_too_large = 1'b0;
      if (r_idx > n_idx) begin
         res.r_too_large = 1'b1;
      end else if (n_idx < TABLE_SIZE) begin
         res.binom_value = mod_product(mod_product(fact_mod[n_idx],
                                                   mod_inverse(fact_mod[n_idx - r_idx])),
                                       mod_inverse(fact_mod[r_idx]));
      end
      return res;
   endfunction

   initial begin
      fact_mod[0] = VAL_W'(1);
      for (int i = 1; i < TABLE_SIZE; i++) begin
         fact_mod[i] = mod_product(fact_mod[i-1], VAL_W'(i));
      end
   end

   // Results are retired before the request of the same edge is logged.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_binoms.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("unexpected result: value %0d flag %0b",
                           rsp_data.binom_value, rsp_data.r_too_large);
               end
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = pending_binoms.pop_front();
               if (rsp_data.binom_value !== want.binom_value ||
                   rsp_data.r_too_large !== want.r_too_large) begin
                  if (mismatch_count < REPORT_LIMIT) begin
                     $display({"binom mismatch: expected value %0d flag %0b, ",
                               "got value %0d flag %0b"},
                              want.binom_value, want.r_too_large,
                              rsp_data.binom_value, rsp_data.r_too_large);
                  end
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_binoms.insert(pending_binoms.size(), predict_binom(req_data));
         end
         outstanding <= pending_binoms.size();
      end
   end

endmodule

FILE: tb/binomial_mod_prime_core_tb.sv
// Testbench top for the binomial coefficient core: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module binomial_mod_prime_core_tb;
   import bmp_pkg::*;

   localparam int RANDOM_ITEMS   = 930;
   localparam int CYCLE_LIMIT    = 3000000;
   localparam int SQUEEZE_AT     = 300;
   localparam int SQUEEZE_CYCLES = 1500;
   localparam int CALM_FIRST     = 600;
   localparam int CALM_LAST      = 700;
   localparam int SETTLE_CYCLES  = 300;

   // Directed requests as {n, r}: edges of both fields, r above n, alternating bit patterns.
   localparam logic [2*ARG_W-1:0] DIRECTED [20] = '{
      {12'd0,    12'd0},    {12'd1,    12'd0},    {12'd1,    12'd1},    {12'd2,    12'd1},
      {12'd4095, 12'd0},    {12'd4095, 12'd4095}, {12'd4095, 12'd1},    {12'd4095, 12'd4094},
      {12'd4095, 12'd2047}, {12'd4094, 12'd2047}, {12'd0,    12'd1},    {12'd0,    12'd4095},
      {12'd4094, 12'd4095}, {12'd2047, 12'd2048}, {12'hAAA,  12'h555},  {12'h555,  12'hAAA},
      {12'hFFF,  12'h800},  {12'h800,  12'h7FF},  {12'd1000, 12'd500},  {12'd3,    12'd2}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int sent_count    = 0;
   int cycle_count   = 0;
   bit squeeze_done  = 1'b0;

   binomial_mod_prime_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   binomial_mod_prime_core_checker binom_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   function automatic bit calm_window();
      return sent_count >= CALM_FIRST && sent_count < CALM_LAST;
   endfunction

   // Offer one request after an optional gap and hold it until the core takes it.
   task automatic offer_request(input logic [ARG_W-1:0] n, input logic [ARG_W-1:0] r);
      int gap;
      gap = calm_window() ? 0 : idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data.n_total  <= n;
      req_data.r_chosen <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // Result side: random stalls, one long hold-off to back up the core, and a calm stretch.
   initial begin
      logic hold;
      int   span;
      @(posedge clock);
      forever begin
         if (!squeeze_done && sent_count >= SQUEEZE_AT) begin
            hold         = 1'b1;
            span         = SQUEEZE_CYCLES;
            squeeze_done = 1'b1;
         end else if (calm_window()) begin
            hold = 1'b0;
            span = 1;
         end else begin
            hold = ($urandom_range(0, 3) == 0);
            span = hold ? idle_cycles() + 1 : $urandom_range(1, 8);
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   // Request stimulus and the verdict.
   initial begin
      logic [ARG_W-1:0] n;
      logic [ARG_W-1:0] r;
      int               pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) begin
         offer_request(DIRECTED[i][2*ARG_W-1:ARG_W], DIRECTED[i][ARG_W-1:0]);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            // r above n.
            n = ARG_W'($urandom_range(0, 4094));
            r = ARG_W'($urandom_range(n + 1, 4095));
         end else if (pick < 25) begin
            n = ARG_W'($urandom_range(0, 24));
            r = ARG_W'($urandom_range(0, n));
         end else begin
            n = ARG_W'($urandom_range(0, 4095));
            case ($urandom_range(0, 7))
               0: begin
                  r = '0;
               end
               1: begin
                  r = n;
               end
               default: begin
                  r = ARG_W'($urandom_range(0, n));
               end
            endcase
         end
         offer_request(n, r);
      end
      req_valid <= 1'b0;

      // Let the count of the last request settle, then drain and look for any stray result.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
